>>> design/pddm_pkg.sv
// Shared types and constants for the PID differential-drive mixer.
package pddm_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET_POSITION = 3'd0,
    REG_GAIN_P          = 3'd1,
    REG_GAIN_I          = 3'd2,
    REG_GAIN_D          = 3'd3,
    REG_BASE_LEFT       = 3'd4,
    REG_BASE_RIGHT      = 3'd5,
    REG_DUTY_MAX        = 3'd6
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic signed [7:0] TARGET_RST   = 8'sd0;
  localparam logic [15:0]       GAIN_P_RST   = 16'd400;
  localparam logic [15:0]       GAIN_I_RST   = 16'd0;
  localparam logic [15:0]       GAIN_D_RST   = 16'd2400;
  localparam logic [15:0]       BASE_RST     = 16'd0;
  localparam logic [15:0]       DUTY_MAX_RST = 16'd7200;

  // Integral limits
  localparam logic signed [23:0] SUM_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SUM_MIN = 24'sh800000;

  // Correction limits
  localparam logic signed [31:0] CORR_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] CORR_MIN = 32'sh80000000;

  // Product and sum widths
  localparam int unsigned PROD_P_W = 26;
  localparam int unsigned PROD_I_W = 41;
  localparam int unsigned PROD_D_W = 27;
  localparam int unsigned TOTAL_W  = 42;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
  } gain_cfg_t;

  typedef struct packed {
    logic [15:0] base_left;
    logic [15:0] base_right;
    logic [15:0] duty_max;
  } mix_cfg_t;

endpackage

>>> design/pddm_err.sv
// Error stage: error, saturating integral, difference; holds the loop state.
module pddm_err (
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [7:0]   target_position,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [7:0]   in_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [8:0]   err_o,
  output logic signed [23:0]  sum_o,
  output logic signed [9:0]   diff_o
);
  import pddm_pkg::*;

  logic               valid_r;
  logic signed [8:0]  err_r;
  logic signed [23:0] sum_r;
  logic signed [9:0]  diff_r;
  logic signed [23:0] error_sum_r;
  logic signed [8:0]  prev_error_r;

  logic               load;
  logic signed [8:0]  err_nxt;
  logic signed [24:0] sum_wide;
  logic signed [23:0] sum_nxt;
  logic signed [9:0]  diff_nxt;

  assign in_stall = valid_r && out_stall;
  assign load     = in_valid && !in_stall;

  // error, saturated integral and error difference
  always_comb begin
    err_nxt  = {target_position[7], target_position} - {in_position[7], in_position};
    sum_wide = {error_sum_r[23], error_sum_r} + {{16{err_nxt[8]}}, err_nxt};
    if (sum_wide[24] != sum_wide[23]) begin
      sum_nxt = sum_wide[24] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_nxt = sum_wide[23:0];
    end
    diff_nxt = {err_nxt[8], err_nxt} - {prev_error_r[8], prev_error_r};
  end

  // stage valid and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      error_sum_r  <= '0;
      prev_error_r <= '0;
    end else if (load) begin
      valid_r      <= 1'b1;
      error_sum_r  <= sum_nxt;
      prev_error_r <= err_nxt;
    end else if (!out_stall) begin
      valid_r      <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      err_r  <= err_nxt;
      sum_r  <= sum_nxt;
      diff_r <= diff_nxt;
    end
  end

  assign out_valid = valid_r;
  assign err_o     = err_r;
  assign sum_o     = sum_r;
  assign diff_o    = diff_r;

endmodule

>>> design/pddm_mul.sv
// Multiply stage: the three gain products, registered.
module pddm_mul (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  pddm_pkg::gain_cfg_t                     gains,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [8:0]                       err_i,
  input  logic signed [23:0]                      sum_i,
  input  logic signed [9:0]                       diff_i,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [pddm_pkg::PROD_P_W-1:0]    prod_p_o,
  output logic signed [pddm_pkg::PROD_I_W-1:0]    prod_i_o,
  output logic signed [pddm_pkg::PROD_D_W-1:0]    prod_d_o
);
  import pddm_pkg::*;

  logic                       valid_r;
  logic signed [PROD_P_W-1:0] prod_p_r;
  logic signed [PROD_I_W-1:0] prod_i_r;
  logic signed [PROD_D_W-1:0] prod_d_r;
  logic signed [PROD_P_W-1:0] prod_p_nxt;
  logic signed [PROD_I_W-1:0] prod_i_nxt;
  logic signed [PROD_D_W-1:0] prod_d_nxt;
  logic                       load;

  assign in_stall = valid_r && out_stall;
  assign load     = in_valid && !in_stall;

  // unsigned gains zero-extended into signed products
  always_comb begin
    prod_p_nxt = $signed({1'b0, gains.gain_p}) * err_i;
    prod_i_nxt = $signed({1'b0, gains.gain_i}) * sum_i;
    prod_d_nxt = $signed({1'b0, gains.gain_d}) * diff_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_p_r <= prod_p_nxt;
      prod_i_r <= prod_i_nxt;
      prod_d_r <= prod_d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign prod_p_o  = prod_p_r;
  assign prod_i_o  = prod_i_r;
  assign prod_d_o  = prod_d_r;

endmodule

>>> design/pddm_sum.sv
// Sum stage: adds the three products and saturates to signed 32 bits.
module pddm_sum (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [pddm_pkg::PROD_P_W-1:0]    prod_p_i,
  input  logic signed [pddm_pkg::PROD_I_W-1:0]    prod_i_i,
  input  logic signed [pddm_pkg::PROD_D_W-1:0]    prod_d_i,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [31:0]                      corr_o
);
  import pddm_pkg::*;

  logic                      valid_r;
  logic signed [31:0]        corr_r;
  logic signed [31:0]        corr_nxt;
  logic signed [TOTAL_W-1:0] total;
  logic                      load;

  assign in_stall = valid_r && out_stall;
  assign load     = in_valid && !in_stall;

  // exact sum, then clamp when the upper bits are not a sign extension
  always_comb begin
    total = {{(TOTAL_W-PROD_P_W){prod_p_i[PROD_P_W-1]}}, prod_p_i}
          + {{(TOTAL_W-PROD_I_W){prod_i_i[PROD_I_W-1]}}, prod_i_i}
          + {{(TOTAL_W-PROD_D_W){prod_d_i[PROD_D_W-1]}}, prod_d_i};
    if (total[TOTAL_W-1:31] == '0 || total[TOTAL_W-1:31] == '1) begin
      corr_nxt = total[31:0];
    end else begin
      corr_nxt = total[TOTAL_W-1] ? CORR_MIN : CORR_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      corr_r <= corr_nxt;
    end
  end

  assign out_valid = valid_r;
  assign corr_o    = corr_r;

endmodule

>>> design/pddm_mix.sv
// Mix stage: differential duties, clamping, and the result register.
module pddm_mix (
  input  logic                clk,
  input  logic                rst_n,
  input  pddm_pkg::mix_cfg_t  mix,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  corr_i,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_left_duty,
  output logic [15:0]         out_right_duty,
  output logic signed [31:0]  out_correction
);
  import pddm_pkg::*;

  logic               valid_r;
  logic [15:0]        left_r;
  logic [15:0]        right_r;
  logic signed [31:0] corr_r;
  logic [15:0]        left_nxt;
  logic [15:0]        right_nxt;
  logic signed [33:0] left_raw;
  logic signed [33:0] right_raw;
  logic signed [33:0] limit;
  logic               load;

  assign in_stall = valid_r && out_stall;
  assign load     = in_valid && !in_stall;

  // duty = base -/+ correction, clamped to 0..duty_max
  always_comb begin
    limit     = $signed({18'd0, mix.duty_max});
    left_raw  = $signed({18'd0, mix.base_left})  - {{2{corr_i[31]}}, corr_i};
    right_raw = $signed({18'd0, mix.base_right}) + {{2{corr_i[31]}}, corr_i};
    if (left_raw < 0) begin
      left_nxt = '0;
    end else if (left_raw > limit) begin
      left_nxt = mix.duty_max;
    end else begin
      left_nxt = left_raw[15:0];
    end
    if (right_raw < 0) begin
      right_nxt = '0;
    end else if (right_raw > limit) begin
      right_nxt = mix.duty_max;
    end else begin
      right_nxt = right_raw[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      corr_r  <= corr_i;
    end
  end

  assign out_valid      = valid_r;
  assign out_left_duty  = left_r;
  assign out_right_duty = right_r;
  assign out_correction = corr_r;

endmodule

>>> design/pid_differential_drive_mixer_core.sv
// Top level of the PID differential-drive mixer: config registers and stage chain.
//
// Usage:
//   Input channel (in_valid / in_stall / in_position) takes one line-position
//   word. Each word gives exactly one result word on the output channel
//   (out_valid / out_stall / out_left_duty, out_right_duty, out_correction).
//   Configuration is a write port (cfg_we, cfg_index, cfg_data); write only
//   while no word is in flight. Index 7 is ignored.
//   Throughput: one word per cycle while the receiver does not stall, set by
//   four registered stages (error/integral, three gain multipliers, product
//   sum with saturation, duty mix and clamp).
//   The integral and previous error update in the first stage as a word is
//   accepted, so successive words see each other's state with no gap.
//   Reset (rst_n low, synchronous) empties all stages, clears the integral
//   and previous error, and loads the register defaults.
//   When the receiver stalls, the result holds in the output register; the
//   stages behind it keep filling, and in_stall rises only once every stage
//   is occupied.
module pid_differential_drive_mixer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [7:0]   in_position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_left_duty,
  output logic [15:0]         out_right_duty,
  output logic signed [31:0]  out_correction
);
  import pddm_pkg::*;

  logic signed [7:0] target_r;
  gain_cfg_t         gains_r;
  mix_cfg_t          mix_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r           <= TARGET_RST;
      gains_r.gain_p     <= GAIN_P_RST;
      gains_r.gain_i     <= GAIN_I_RST;
      gains_r.gain_d     <= GAIN_D_RST;
      mix_r.base_left    <= BASE_RST;
      mix_r.base_right   <= BASE_RST;
      mix_r.duty_max     <= DUTY_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_POSITION: target_r         <= cfg_data[7:0];
        REG_GAIN_P:          gains_r.gain_p   <= cfg_data;
        REG_GAIN_I:          gains_r.gain_i   <= cfg_data;
        REG_GAIN_D:          gains_r.gain_d   <= cfg_data;
        REG_BASE_LEFT:       mix_r.base_left  <= cfg_data;
        REG_BASE_RIGHT:      mix_r.base_right <= cfg_data;
        REG_DUTY_MAX:        mix_r.duty_max   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage links
  logic                       e_valid, e_stall;
  logic signed [8:0]          e_err;
  logic signed [23:0]         e_sum;
  logic signed [9:0]          e_diff;
  logic                       m_valid, m_stall;
  logic signed [PROD_P_W-1:0] m_prod_p;
  logic signed [PROD_I_W-1:0] m_prod_i;
  logic signed [PROD_D_W-1:0] m_prod_d;
  logic                       s_valid, s_stall;
  logic signed [31:0]         s_corr;

  pddm_err u_err (
    .clk             (clk),
    .rst_n           (rst_n),
    .target_position (target_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_position     (in_position),
    .out_valid       (e_valid),
    .out_stall       (e_stall),
    .err_o           (e_err),
    .sum_o           (e_sum),
    .diff_o          (e_diff)
  );

  pddm_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .gains     (gains_r),
    .in_valid  (e_valid),
    .in_stall  (e_stall),
    .err_i     (e_err),
    .sum_i     (e_sum),
    .diff_i    (e_diff),
    .out_valid (m_valid),
    .out_stall (m_stall),
    .prod_p_o  (m_prod_p),
    .prod_i_o  (m_prod_i),
    .prod_d_o  (m_prod_d)
  );

  pddm_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (m_valid),
    .in_stall  (m_stall),
    .prod_p_i  (m_prod_p),
    .prod_i_i  (m_prod_i),
    .prod_d_i  (m_prod_d),
    .out_valid (s_valid),
    .out_stall (s_stall),
    .corr_o    (s_corr)
  );

  pddm_mix u_mix (
    .clk            (clk),
    .rst_n          (rst_n),
    .mix            (mix_r),
    .in_valid       (s_valid),
    .in_stall       (s_stall),
    .corr_i         (s_corr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_duty  (out_left_duty),
    .out_right_duty (out_right_duty),
    .out_correction (out_correction)
  );

endmodule

>>> bench/testbench.sv
// Self-checking bench for the PID differential-drive mixer: directed rows, random phases.
module testbench;
  import pddm_pkg::*;

  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  // Integral and correction rails for the duty predictor
  localparam longint INTEG_HI = 64'sd8388607;
  localparam longint INTEG_LO = -64'sd8388608;
  localparam longint CORR_HI  = 64'sd2147483647;
  localparam longint CORR_LO  = -64'sd2147483648;

  typedef struct packed {
    logic [15:0]        left_duty;
    logic [15:0]        right_duty;
    logic signed [31:0] correction;
  } mix_result_t;

  localparam mix_result_t NO_RESULT = '0;

  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         idx;
    logic [15:0]        data;
    logic signed [7:0]  pos;
    logic               typed;
    mix_result_t        want;
  } drill_row_t;

  typedef enum {POS_UNIFORM, POS_NEAR, POS_PUSH_UP, POS_PUSH_DOWN} pos_mode_t;

  function automatic drill_row_t reg_row(input logic [2:0] idx, input logic [15:0] data);
    drill_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.data = data;
    return r;
  endfunction

  function automatic drill_row_t word_row(input logic signed [7:0] pos);
    drill_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.pos  = pos;
    return r;
  endfunction

  function automatic drill_row_t checked_row(input logic signed [7:0] pos,
                                             input logic [15:0] left, input logic [15:0] right,
                                             input logic signed [31:0] corr);
    drill_row_t r;
    r = word_row(pos);
    r.typed = 1'b1;
    r.want  = '{left, right, corr};
    return r;
  endfunction

  // Directed rows: defaults after reset, full-scale gains, ignored index, zero clamp
  localparam int N_ROWS = 35;
  localparam drill_row_t DIRECTED_ROWS [N_ROWS] = '{
    checked_row(8'sd0, 16'd0, 16'd0, 32'sd0),
    checked_row(-8'sd128, 16'd0, 16'd7200, 32'sd358400),
    checked_row(8'sd127, 16'd7200, 16'd0, -32'sd662800),
    word_row(8'sd1),
    word_row(-8'sd1),
    reg_row(REG_TARGET_POSITION, 16'hA57F),   // upper byte must be dropped
    reg_row(REG_GAIN_P, 16'hFFFF),
    reg_row(REG_GAIN_I, 16'hFFFF),
    reg_row(REG_GAIN_D, 16'hFFFF),
    reg_row(REG_BASE_LEFT, 16'hFFFF),
    reg_row(REG_BASE_RIGHT, 16'h0000),
    reg_row(REG_DUTY_MAX, 16'hFFFF),
    word_row(-8'sd128),
    word_row(-8'sd128),
    word_row(8'sd127),
    word_row(-8'sd128),
    reg_row(REG_UNMAPPED, 16'h0000),          // must not touch any register
    word_row(8'sd0),
    reg_row(REG_DUTY_MAX, 16'h0000),
    word_row(8'sd127),
    word_row(-8'sd128),
    reg_row(REG_GAIN_P, 16'd0),
    reg_row(REG_GAIN_I, 16'd0),
    reg_row(REG_GAIN_D, 16'd0),
    reg_row(REG_BASE_LEFT, 16'd1234),
    reg_row(REG_BASE_RIGHT, 16'd4321),
    reg_row(REG_DUTY_MAX, 16'd2000),
    checked_row(8'sd55, 16'd1234, 16'd2000, 32'sd0),
    reg_row(REG_TARGET_POSITION, 16'h0080),
    reg_row(REG_GAIN_P, 16'd400),
    reg_row(REG_GAIN_D, 16'd2400),
    reg_row(REG_GAIN_I, 16'd3),
    word_row(8'sd127),
    word_row(-8'sd128),
    word_row(8'sd127)
  };

  localparam pos_mode_t PHASE_PLAN [8] = '{POS_UNIFORM, POS_PUSH_UP, POS_NEAR, POS_PUSH_DOWN,
                                           POS_PUSH_DOWN, POS_UNIFORM, POS_PUSH_UP, POS_NEAR};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [7:0]  in_position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [15:0]        out_left_duty;
  logic [15:0]        out_right_duty;
  logic signed [31:0] out_correction;

  // Predictor copy of the registers and loop state
  logic signed [7:0]  target_set = 8'sd0;
  gain_cfg_t          gain_set = '{16'd400, 16'd0, 16'd2400};
  mix_cfg_t           mix_set = '{16'd0, 16'd0, 16'd7200};
  logic signed [23:0] integ_acc = '0;
  logic signed [8:0]  prev_err = '0;

  mix_result_t pending_duties[$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_span = 0;
  int unsigned stall_run = 0;

  pid_differential_drive_mixer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_duty  (out_left_duty),
    .out_right_duty (out_right_duty),
    .out_correction (out_correction)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [15:0] clamp_duty(input longint v);
    if (v > longint'(mix_set.duty_max)) v = longint'(mix_set.duty_max);
    if (v < 0) v = 0;
    return 16'(v);
  endfunction

  // One PID step: error, saturating integral, saturated correction, mixed duties
  function automatic mix_result_t pid_mix_step(input logic signed [7:0] pos);
    longint err, sum, corr;
    mix_result_t r;
    err = longint'(target_set) - longint'(pos);
    sum = longint'(integ_acc) + err;
    if (sum > INTEG_HI) sum = INTEG_HI;
    if (sum < INTEG_LO) sum = INTEG_LO;
    integ_acc = 24'(sum);
    corr = longint'(gain_set.gain_p) * err + longint'(gain_set.gain_i) * sum
         + longint'(gain_set.gain_d) * (err - longint'(prev_err));
    if (corr > CORR_HI) corr = CORR_HI;
    if (corr < CORR_LO) corr = CORR_LO;
    prev_err = 9'(err);
    r.left_duty  = clamp_duty(longint'(mix_set.base_left) - corr);
    r.right_duty = clamp_duty(longint'(mix_set.base_right) + corr);
    r.correction = 32'(corr);
    return r;
  endfunction

  // Register write: holds cfg_we high; caller drops it before sending words
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_TARGET_POSITION: target_set = data[7:0];
      REG_GAIN_P:          gain_set.gain_p = data;
      REG_GAIN_I:          gain_set.gain_i = data;
      REG_GAIN_D:          gain_set.gain_d = data;
      REG_BASE_LEFT:       mix_set.base_left = data;
      REG_BASE_RIGHT:      mix_set.base_right = data;
      REG_DUTY_MAX:        mix_set.duty_max = data;
      default: ;
    endcase
  endtask

  // Present one position word and hold it until taken
  task automatic send_position(input logic signed [7:0] pos, input logic typed,
                               input mix_result_t want);
    mix_result_t predicted;
    in_valid    <= 1'b1;
    in_position <= pos;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = pid_mix_step(pos);
    pending_duties.push_back(typed ? want : predicted);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Bursts of back-to-back words with random gaps in between
  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
    end
    burst_left--;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_duties.size() != 0);
  endtask

  function automatic logic [15:0] pick_u16();
    case ($urandom_range(0, 3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic signed [7:0] next_position(input pos_mode_t mode);
    int v;
    case (mode)
      POS_NEAR: begin
        v = int'(target_set) + int'($urandom_range(0, 16)) - 8;
        if (v > 127) v = 127;
        if (v < -128) v = -128;
        return 8'(v);
      end
      POS_PUSH_UP:   return 8'(int'($urandom_range(0, 63)) - 128);
      POS_PUSH_DOWN: return 8'($urandom_range(64, 127));
      default:       return 8'($urandom());
    endcase
  endfunction

  // New register set per phase; push phases pin the target and full integral gain
  task automatic configure_phase(input pos_mode_t mode);
    logic [15:0] tgt;
    logic        push;
    tgt  = 16'($urandom());
    push = (mode == POS_PUSH_UP) || (mode == POS_PUSH_DOWN);
    if (mode == POS_PUSH_UP) tgt[7:0] = 8'h7F;
    if (mode == POS_PUSH_DOWN) tgt[7:0] = 8'h80;
    write_reg(REG_TARGET_POSITION, tgt);
    write_reg(REG_GAIN_P, pick_u16());
    write_reg(REG_GAIN_I, push ? 16'hFFFF : pick_u16());
    write_reg(REG_GAIN_D, pick_u16());
    write_reg(REG_BASE_LEFT, pick_u16());
    write_reg(REG_BASE_RIGHT, pick_u16());
    write_reg(REG_DUTY_MAX, pick_u16());
    if ($urandom_range(0, 1) == 1) write_reg(REG_UNMAPPED, 16'($urandom()));
    cfg_we <= 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Receiver back-pressure: the pattern is redrawn each time the span counter runs out
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 4);
      stall_span <= 64;
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0, 1: out_stall <= 1'b0;
      2:    out_stall <= ($urandom_range(0, 3) == 0);
      3:    out_stall <= ($urandom_range(0, 1) == 0);
      default: begin
        // long holds, alternating
        if (stall_run == 0) begin
          out_stall <= ~out_stall;
          stall_run <= $urandom_range(1, 12);
        end else begin
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  // Result checker: each taken word against the oldest expectation
  always @(posedge clk) begin
    mix_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_duties.size() == 0) begin
        flag_mismatch("result word with nothing pending", 0, 0);
      end else begin
        want = pending_duties.pop_front();
        if (out_left_duty !== want.left_duty)
          flag_mismatch("left_duty", out_left_duty, want.left_duty);
        if (out_right_duty !== want.right_duty)
          flag_mismatch("right_duty", out_right_duty, want.right_duty);
        if (out_correction !== want.correction)
          flag_mismatch("correction", out_correction, want.correction);
      end
    end
  end

  initial begin
    int unsigned n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; writes only once the pipe has drained
    for (int r = 0; r < N_ROWS; r++) begin
      if (DIRECTED_ROWS[r].kind == ROW_WRITE) begin
        if (!cfg_we) wait_for_results();
        write_reg(DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].data);
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        pace_sender();
        send_position(DIRECTED_ROWS[r].pos, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
      end
    end

    // Random phases, each under a fresh register set
    for (int p = 0; p < 8; p++) begin
      wait_for_results();
      configure_phase(PHASE_PLAN[p]);
      n = (PHASE_PLAN[p] == POS_PUSH_UP || PHASE_PLAN[p] == POS_PUSH_DOWN) ? 200 : 100;
      repeat (n) begin
        pace_sender();
        send_position(next_position(PHASE_PLAN[p]), 1'b0, NO_RESULT);
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_duties.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
